// ===== hdl/wpb_pkg.sv =====
package wpb_pkg;

   // field widths
   localparam int COL_W    = 16;
   localparam int IN_WGT_W = 16;
   localparam int WGT_W    = 20;
   localparam int TOT_W    = WGT_W + 1;
   localparam int PROD_S_W = WGT_W + COL_W;
   localparam int PROD_I_W = IN_WGT_W + COL_W;
   localparam int NUM_W    = PROD_S_W + 1;
   localparam int LX_W     = 10;
   localparam int LY_W     = 9;
   localparam int MODE_W   = 2;
   localparam int NUM_CH   = 3;
   localparam int CNT_W    = $clog2(COL_W);

   // configuration port
   localparam int PADDR_W = 4;
   localparam int PDATA_W = 32;
   localparam logic [1:0] REG_BLEND_MODE = 2'd0;
   localparam logic [1:0] REG_OFFSET_X   = 2'd1;
   localparam logic [1:0] REG_OFFSET_Y   = 2'd2;

   // blend modes, code 3 behaves as the weighted blend
   localparam logic [MODE_W-1:0] MODE_OVERWRITE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_AVERAGE   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_WEIGHTED  = 2'd2;

   localparam logic CMD_BLEND = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   localparam logic [COL_W-1:0] RED_ONE    = 16'd4096;
   localparam logic [WGT_W-1:0] WEIGHT_MAX = '1;
   localparam logic [CNT_W-1:0] DIV_LAST   = CNT_W'(COL_W - 1);

   typedef struct packed {
      logic [COL_W-1:0] red;
      logic [COL_W-1:0] green;
      logic [COL_W-1:0] blue;
      logic [WGT_W-1:0] weight;
      logic             covered;
   } pixel_word_type;

   localparam pixel_word_type RESET_WORD = '{
      red: RED_ONE, green: '0, blue: '0, weight: '0, covered: 1'b0
   };

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CALC,
      ST_MUL,
      ST_DIV,
      ST_FIN
   } state_type;

endpackage

// ===== hdl/weighted_panorama_blend.sv =====
// Panorama store with weighted blending of tile pixels.
// req channel: one word per pixel; req_cmd selects blend (tile coordinates,
// shifted by offset_x/offset_y) or read (panorama coordinates).
// rsp channel: one word per request with the stored pixel after the step,
// all zero when the pixel lies outside the panorama.
// Configuration: APB-style port, blend_mode at 0x0, offset_x at 0x4,
// offset_y at 0x8; write only while no request is in flight.
// Sequence: the store is one memory with a registered read; a read, a
// skipped pixel, overwrite, average or a first weighted write is accepted,
// then read, modified and written back, and the response is registered.
// A weighted blend on a covered pixel adds a multiply, a sum and a
// bit-serial divide before the write. A new word is taken only after the
// last one is written back.
// Reset: a clearing pass writes every entry with red 1.0, weight 0, not
// covered; req_ready stays low until it ends.
// Stall: a response waits in its output register; the next request is
// accepted meanwhile and holds in its final cycle until the register frees.
module weighted_panorama_blend #(
   parameter int unsigned PANO_WIDTH  = 1024,
   parameter int unsigned PANO_HEIGHT = 512
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_cmd,
   input  logic [wpb_pkg::LX_W-1:0]            req_local_x,
   input  logic [wpb_pkg::LY_W-1:0]            req_local_y,
   input  logic                                req_pixel_valid,
   input  logic [wpb_pkg::COL_W-1:0]           req_in_red,
   input  logic [wpb_pkg::COL_W-1:0]           req_in_green,
   input  logic [wpb_pkg::COL_W-1:0]           req_in_blue,
   input  logic [wpb_pkg::IN_WGT_W-1:0]        req_in_weight,

   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [wpb_pkg::COL_W-1:0]           rsp_out_red,
   output logic [wpb_pkg::COL_W-1:0]           rsp_out_green,
   output logic [wpb_pkg::COL_W-1:0]           rsp_out_blue,
   output logic [wpb_pkg::WGT_W-1:0]           rsp_out_weight,
   output logic                                rsp_covered,
   output logic                                rsp_was_written,

   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [wpb_pkg::PADDR_W-1:0]         paddr,
   input  logic [wpb_pkg::PDATA_W-1:0]         pwdata,
   output logic [wpb_pkg::PDATA_W-1:0]         prdata,
   output logic                                pready
);

   localparam int XW    = $clog2(PANO_WIDTH);
   localparam int YW    = $clog2(PANO_HEIGHT);
   localparam int PXW   = (XW + 1 > wpb_pkg::LX_W + 1) ? XW + 1 : wpb_pkg::LX_W + 1;
   localparam int PYW   = (YW + 1 > wpb_pkg::LY_W + 1) ? YW + 1 : wpb_pkg::LY_W + 1;
   localparam int AW    = XW + YW;
   localparam int DEPTH = 2 ** AW;

   localparam int CW  = wpb_pkg::COL_W;
   localparam int NCH = wpb_pkg::NUM_CH;

   // configuration registers
   logic [wpb_pkg::MODE_W-1:0] blend_mode_ff;
   logic [wpb_pkg::LX_W-1:0]   offset_x_ff;
   logic [wpb_pkg::LY_W-1:0]   offset_y_ff;
   logic                       csr_write;

   // control
   wpb_pkg::state_type state_ff, state_in;
   logic [AW-1:0]      clr_addr_ff;
   logic [wpb_pkg::CNT_W-1:0] div_cnt_ff;
   logic               req_fire;
   logic               out_free;
   logic               rsp_load;

   // item registers
   logic               cmd_ff;
   logic               valid_ff;
   logic               in_range_ff;
   logic [AW-1:0]      addr_ff;
   logic [CW-1:0]      in_col_ff [NCH];
   logic [wpb_pkg::IN_WGT_W-1:0] in_weight_ff;

   // address of an incoming word
   logic [PXW-1:0]     px;
   logic [PYW-1:0]     py;
   logic               in_range;
   logic [AW-1:0]      rd_addr;

   // memory
   wpb_pkg::pixel_word_type pano_mem [DEPTH];
   wpb_pkg::pixel_word_type rd_data_ff;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   wpb_pkg::pixel_word_type wr_data;

   // read-modify-write
   logic [CW-1:0]      st_col [NCH];
   logic [CW:0]        avg_sum [NCH];
   logic               is_blend;
   logic               need_div;
   logic               calc_written;
   logic [wpb_pkg::TOT_W-1:0] calc_total;
   wpb_pkg::pixel_word_type new_word;
   wpb_pkg::pixel_word_type calc_word;
   wpb_pkg::pixel_word_type div_word;

   // weighted blend datapath
   logic [wpb_pkg::PROD_S_W-1:0] prod_s_ff [NCH];
   logic [wpb_pkg::PROD_I_W-1:0] prod_i_ff [NCH];
   logic [wpb_pkg::TOT_W-1:0]    total_ff;
   logic [wpb_pkg::TOT_W-1:0]    rem_ff [NCH];
   logic [CW-1:0]                quo_ff [NCH];
   logic [wpb_pkg::NUM_W-1:0]    num [NCH];
   logic [wpb_pkg::TOT_W:0]      trial [NCH];
   logic [wpb_pkg::TOT_W:0]      diff [NCH];
   logic                         ge [NCH];

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   wpb_pkg::pixel_word_type rsp_word_ff, rsp_word_in;
   logic               rsp_written_ff, rsp_written_in;

   // ---------------- configuration port ----------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         blend_mode_ff <= wpb_pkg::MODE_WEIGHTED;
         offset_x_ff   <= '0;
         offset_y_ff   <= '0;
      end else if (csr_write) begin
         case (paddr[3:2])
            wpb_pkg::REG_BLEND_MODE: blend_mode_ff <= pwdata[wpb_pkg::MODE_W-1:0];
            wpb_pkg::REG_OFFSET_X:   offset_x_ff   <= pwdata[wpb_pkg::LX_W-1:0];
            wpb_pkg::REG_OFFSET_Y:   offset_y_ff   <= pwdata[wpb_pkg::LY_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         wpb_pkg::REG_BLEND_MODE: prdata = wpb_pkg::PDATA_W'(blend_mode_ff);
         wpb_pkg::REG_OFFSET_X:   prdata = wpb_pkg::PDATA_W'(offset_x_ff);
         wpb_pkg::REG_OFFSET_Y:   prdata = wpb_pkg::PDATA_W'(offset_y_ff);
         default:                 prdata = '0;
      endcase
   end

   // ---------------- address of an incoming word ----------------
   always_comb begin
      if (req_cmd == wpb_pkg::CMD_BLEND) begin
         px = PXW'(offset_x_ff) + PXW'(req_local_x);
         py = PYW'(offset_y_ff) + PYW'(req_local_y);
      end else begin
         px = PXW'(req_local_x);
         py = PYW'(req_local_y);
      end
      in_range = (32'(px) < 32'(PANO_WIDTH)) && (32'(py) < 32'(PANO_HEIGHT));
      rd_addr  = {py[YW-1:0], px[XW-1:0]};
   end

   assign req_fire = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff       <= req_cmd;
         valid_ff     <= req_pixel_valid;
         in_range_ff  <= in_range;
         addr_ff      <= rd_addr;
         in_col_ff[0] <= req_in_red;
         in_col_ff[1] <= req_in_green;
         in_col_ff[2] <= req_in_blue;
         in_weight_ff <= req_in_weight;
      end
   end

   // ---------------- pixel store ----------------
   always_ff @(posedge clock) begin
      if (wr_en) begin
         pano_mem[wr_addr] <= wr_data;
      end
      if (req_fire) begin
         rd_data_ff <= pano_mem[rd_addr];
      end
   end

   // ---------------- read-modify-write for the short paths ----------------
   assign st_col[0] = rd_data_ff.red;
   assign st_col[1] = rd_data_ff.green;
   assign st_col[2] = rd_data_ff.blue;

   always_comb begin
      for (int c = 0; c < NCH; c++) begin
         avg_sum[c] = (CW + 1)'(st_col[c]) + (CW + 1)'(in_col_ff[c]);
      end
      is_blend     = (cmd_ff == wpb_pkg::CMD_BLEND) && valid_ff && in_range_ff;
      calc_total   = wpb_pkg::TOT_W'(rd_data_ff.weight) + wpb_pkg::TOT_W'(in_weight_ff);
      new_word     = rd_data_ff;
      calc_written = 1'b0;
      need_div     = 1'b0;
      if (is_blend) begin
         if (blend_mode_ff == wpb_pkg::MODE_OVERWRITE || !rd_data_ff.covered) begin
            new_word.red     = in_col_ff[0];
            new_word.green   = in_col_ff[1];
            new_word.blue    = in_col_ff[2];
            // weighted modes start the accumulated weight
            if (blend_mode_ff[1]) begin
               new_word.weight = wpb_pkg::WGT_W'(in_weight_ff);
            end
            new_word.covered = 1'b1;
            calc_written     = 1'b1;
         end else if (blend_mode_ff == wpb_pkg::MODE_AVERAGE) begin
            new_word.red   = avg_sum[0][CW:1];
            new_word.green = avg_sum[1][CW:1];
            new_word.blue  = avg_sum[2][CW:1];
            calc_written   = 1'b1;
         end else begin
            // zero total weight leaves the pixel as it is
            need_div = (calc_total != '0);
         end
      end
      calc_word = in_range_ff ? new_word : '0;
   end

   // ---------------- weighted blend: multiply, sum, bit-serial divide ----------------
   always_comb begin
      for (int c = 0; c < NCH; c++) begin
         num[c]   = wpb_pkg::NUM_W'(prod_s_ff[c]) + wpb_pkg::NUM_W'(prod_i_ff[c])
                  + wpb_pkg::NUM_W'(total_ff >> 1);
         trial[c] = {rem_ff[c], quo_ff[c][CW-1]};
         diff[c]  = trial[c] - {1'b0, total_ff};
         ge[c]    = trial[c] >= {1'b0, total_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == wpb_pkg::ST_CALC) begin
         for (int c = 0; c < NCH; c++) begin
            prod_s_ff[c] <= wpb_pkg::PROD_S_W'(rd_data_ff.weight)
                          * wpb_pkg::PROD_S_W'(st_col[c]);
            prod_i_ff[c] <= wpb_pkg::PROD_I_W'(in_weight_ff)
                          * wpb_pkg::PROD_I_W'(in_col_ff[c]);
         end
         total_ff <= calc_total;
      end
      if (state_ff == wpb_pkg::ST_MUL) begin
         // quotient fits 16 bits, so the upper part is already below the divisor
         for (int c = 0; c < NCH; c++) begin
            rem_ff[c] <= num[c][wpb_pkg::NUM_W-1:CW];
            quo_ff[c] <= num[c][CW-1:0];
         end
      end
      if (state_ff == wpb_pkg::ST_DIV) begin
         for (int c = 0; c < NCH; c++) begin
            rem_ff[c] <= ge[c] ? diff[c][wpb_pkg::TOT_W-1:0] : trial[c][wpb_pkg::TOT_W-1:0];
            quo_ff[c] <= {quo_ff[c][CW-2:0], ge[c]};
         end
      end
   end

   always_comb begin
      div_word.red     = quo_ff[0];
      div_word.green   = quo_ff[1];
      div_word.blue    = quo_ff[2];
      div_word.weight  = total_ff[wpb_pkg::TOT_W-1] ? wpb_pkg::WEIGHT_MAX
                                                     : total_ff[wpb_pkg::WGT_W-1:0];
      div_word.covered = 1'b1;
   end

   // ---------------- sequencer ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= wpb_pkg::ST_CLEAR;
         clr_addr_ff <= '0;
         div_cnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == wpb_pkg::ST_CLEAR) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
         if (state_ff == wpb_pkg::ST_DIV) begin
            div_cnt_ff <= (div_cnt_ff == wpb_pkg::DIV_LAST) ? '0 : div_cnt_ff + 1'b1;
         end
      end
   end

   always_comb begin
      state_in       = state_ff;
      req_ready      = 1'b0;
      wr_en          = 1'b0;
      wr_addr        = addr_ff;
      wr_data        = calc_word;
      rsp_load       = 1'b0;
      rsp_word_in    = calc_word;
      rsp_written_in = calc_written;
      case (state_ff)
         wpb_pkg::ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_ff;
            wr_data = wpb_pkg::RESET_WORD;
            if (&clr_addr_ff) begin
               state_in = wpb_pkg::ST_IDLE;
            end
         end
         wpb_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = wpb_pkg::ST_CALC;
            end
         end
         wpb_pkg::ST_CALC: begin
            if (need_div) begin
               state_in = wpb_pkg::ST_MUL;
            end else if (out_free) begin
               wr_en    = calc_written;
               rsp_load = 1'b1;
               state_in = wpb_pkg::ST_IDLE;
            end
         end
         wpb_pkg::ST_MUL: begin
            state_in = wpb_pkg::ST_DIV;
         end
         wpb_pkg::ST_DIV: begin
            if (div_cnt_ff == wpb_pkg::DIV_LAST) begin
               state_in = wpb_pkg::ST_FIN;
            end
         end
         wpb_pkg::ST_FIN: begin
            if (out_free) begin
               wr_en          = 1'b1;
               wr_data        = div_word;
               rsp_load       = 1'b1;
               rsp_word_in    = div_word;
               rsp_written_in = 1'b1;
               state_in       = wpb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wpb_pkg::ST_CLEAR;
         end
      endcase
   end

   // ---------------- response register ----------------
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_word_ff    <= rsp_word_in;
         rsp_written_ff <= rsp_written_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_red     = rsp_word_ff.red;
   assign rsp_out_green   = rsp_word_ff.green;
   assign rsp_out_blue    = rsp_word_ff.blue;
   assign rsp_out_weight  = rsp_word_ff.weight;
   assign rsp_covered     = rsp_word_ff.covered;
   assign rsp_was_written = rsp_written_ff;

   // ---------------- assertions ----------------
   a_accept_to_calc: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == wpb_pkg::ST_CALC))
      else $error("accepted word did not move to read-modify-write");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wpb_pkg::ST_IDLE) |-> !wr_en)
      else $error("store written while idle");

   a_written_covered: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_was_written) |-> rsp_covered)
      else $error("written pixel reported as not covered");

   a_div_count_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != wpb_pkg::ST_DIV) |-> (div_cnt_ff == '0))
      else $error("divider count left running");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> out_free)
      else $error("response register overwritten before it was taken");

endmodule

// ===== verif/wpb_checker.sv =====
module wpb_checker
   import wpb_pkg::*;
#(
   parameter int unsigned PANO_WIDTH  = 1024,
   parameter int unsigned PANO_HEIGHT = 512
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic                  req_cmd,
   input  logic [LX_W-1:0]       req_local_x,
   input  logic [LY_W-1:0]       req_local_y,
   input  logic                  req_pixel_valid,
   input  logic [COL_W-1:0]      req_in_red,
   input  logic [COL_W-1:0]      req_in_green,
   input  logic [COL_W-1:0]      req_in_blue,
   input  logic [IN_WGT_W-1:0]   req_in_weight,

   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [COL_W-1:0]      rsp_out_red,
   input  logic [COL_W-1:0]      rsp_out_green,
   input  logic [COL_W-1:0]      rsp_out_blue,
   input  logic [WGT_W-1:0]      rsp_out_weight,
   input  logic                  rsp_covered,
   input  logic                  rsp_was_written,

   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [PADDR_W-1:0]    paddr,
   input  logic [PDATA_W-1:0]    pwdata,
   input  logic [PDATA_W-1:0]    prdata,
   input  logic                  pready,

   input  logic                  run_done,
   output int                    rsp_seen,
   output int                    failures
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [COL_W-1:0] red;
      logic [COL_W-1:0] green;
      logic [COL_W-1:0] blue;
      logic [WGT_W-1:0] weight;
      logic             covered;
   } pano_pixel_t;

   typedef struct packed {
      logic [COL_W-1:0] red;
      logic [COL_W-1:0] green;
      logic [COL_W-1:0] blue;
      logic [WGT_W-1:0] weight;
      logic             covered;
      logic             was_written;
   } pixel_result_t;

   localparam pano_pixel_t CLEAR_PIXEL = '{
      red: RED_ONE, green: '0, blue: '0, weight: '0, covered: 1'b0
   };

   // only touched pixels are held, the rest read back as cleared
   pano_pixel_t   pano_store [int unsigned];
   pixel_result_t expected_px_q [$];

   logic [MODE_W-1:0] cur_mode;
   logic [LX_W-1:0]   cur_off_x;
   logic [LY_W-1:0]   cur_off_y;
   bit                drain_checked;

   task automatic report_mismatch(input string what);
      $display("%0t: mismatch: %s", $realtime, what);
      failures++;
   endtask

   function automatic logic [COL_W-1:0] norm_mix(input longint unsigned ws, sc, wi, ic,
                                                 input longint unsigned total);
      return COL_W'((ws * sc + wi * ic + total / 2) / total);
   endfunction

   function automatic pixel_result_t apply_pano_step(
      input logic                cmd,
      input logic [LX_W-1:0]     lx,
      input logic [LY_W-1:0]     ly,
      input logic                pix_valid,
      input logic [COL_W-1:0]    r_in,
      input logic [COL_W-1:0]    g_in,
      input logic [COL_W-1:0]    b_in,
      input logic [IN_WGT_W-1:0] w_in
   );
      int unsigned      col, row, idx;
      pano_pixel_t      p;
      pixel_result_t    r;
      longint unsigned  total;
      logic             written;
      written = 1'b0;
      r = '0;
      col = lx;
      row = ly;
      if (cmd == CMD_BLEND) begin
         col += cur_off_x;
         row += cur_off_y;
      end
      if (col >= PANO_WIDTH || row >= PANO_HEIGHT)
         return r;
      idx = row * PANO_WIDTH + col;
      p = pano_store.exists(idx) ? pano_store[idx] : CLEAR_PIXEL;
      if (cmd == CMD_BLEND && pix_valid) begin
         if (cur_mode == MODE_OVERWRITE || !p.covered) begin
            p.red   = r_in;
            p.green = g_in;
            p.blue  = b_in;
            if (cur_mode >= MODE_WEIGHTED)
               p.weight = WGT_W'(w_in);
            p.covered = 1'b1;
            written = 1'b1;
         end else if (cur_mode == MODE_AVERAGE) begin
            p.red   = COL_W'((17'(p.red) + r_in) >> 1);
            p.green = COL_W'((17'(p.green) + g_in) >> 1);
            p.blue  = COL_W'((17'(p.blue) + b_in) >> 1);
            written = 1'b1;
         end else begin
            total = p.weight + w_in;
            // nothing to normalize by, pixel stays as it is
            if (total != 0) begin
               p.red   = norm_mix(p.weight, p.red, w_in, r_in, total);
               p.green = norm_mix(p.weight, p.green, w_in, g_in, total);
               p.blue  = norm_mix(p.weight, p.blue, w_in, b_in, total);
               p.weight = (total > WEIGHT_MAX) ? WEIGHT_MAX : WGT_W'(total);
               written = 1'b1;
            end
         end
         pano_store[idx] = p;
      end
      r = '{red: p.red, green: p.green, blue: p.blue, weight: p.weight,
            covered: p.covered, was_written: written};
      return r;
   endfunction

   always @(posedge clock) begin
      pixel_result_t    want, got, next_want;
      string            bad;
      logic [PDATA_W-1:0] reg_val;
      if (reset) begin
         cur_mode  = MODE_WEIGHTED;
         cur_off_x = '0;
         cur_off_y = '0;
         pano_store.delete();
         expected_px_q.delete();
         rsp_seen <= 0;
      end else begin
         if (psel && penable && pready) begin
            reg_val = '0;
            case (paddr[PADDR_W-1:2])
               REG_BLEND_MODE: begin
                  if (pwrite) cur_mode = pwdata[MODE_W-1:0];
                  reg_val = PDATA_W'(cur_mode);
               end
               REG_OFFSET_X: begin
                  if (pwrite) cur_off_x = pwdata[LX_W-1:0];
                  reg_val = PDATA_W'(cur_off_x);
               end
               REG_OFFSET_Y: begin
                  if (pwrite) cur_off_y = pwdata[LY_W-1:0];
                  reg_val = PDATA_W'(cur_off_y);
               end
               default: reg_val = prdata;
            endcase
            if (!pwrite && prdata !== reg_val)
               report_mismatch($sformatf("register read at %h: got %h, expected %h",
                                         paddr, prdata, reg_val));
         end

         // response first, so a word can never match the request taken at this edge
         if (rsp_valid && rsp_ready) begin
            if (expected_px_q.size() == 0) begin
               report_mismatch("response word with no request outstanding");
            end else begin
               want = expected_px_q.pop_front();
               got = '{red: rsp_out_red, green: rsp_out_green, blue: rsp_out_blue,
                       weight: rsp_out_weight, covered: rsp_covered,
                       was_written: rsp_was_written};
               bad = "";
               if (got.red !== want.red)                 bad = {bad, " red"};
               if (got.green !== want.green)             bad = {bad, " green"};
               if (got.blue !== want.blue)               bad = {bad, " blue"};
               if (got.weight !== want.weight)           bad = {bad, " weight"};
               if (got.covered !== want.covered)         bad = {bad, " covered"};
               if (got.was_written !== want.was_written) bad = {bad, " was_written"};
               if (bad != "")
                  report_mismatch($sformatf(
                     "word %0d bad%s: got %h %h %h w %h c %b wr %b, exp %h %h %h w %h c %b wr %b",
                     rsp_seen, bad, got.red, got.green, got.blue, got.weight, got.covered,
                     got.was_written, want.red, want.green, want.blue, want.weight,
                     want.covered, want.was_written));
            end
            rsp_seen <= rsp_seen + 1;
         end

         if (req_valid && req_ready) begin
            next_want = apply_pano_step(req_cmd, req_local_x, req_local_y,
                                        req_pixel_valid, req_in_red,
                                        req_in_green, req_in_blue,
                                        req_in_weight);
            expected_px_q.insert(expected_px_q.size(), next_want);
         end

         if (run_done && !drain_checked) begin
            drain_checked = 1'b1;
            if (expected_px_q.size() != 0)
               report_mismatch($sformatf("%0d response words never arrived",
                                         expected_px_q.size()));
         end
      end
   end

endmodule

// ===== verif/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import wpb_pkg::*;

   // spare mode code, handled like the weighted blend
   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
   localparam int unsigned HOLD_CYCLES = 400;

   // pixels that keep getting blended so weights pile up to saturation
   localparam int unsigned HOT_X [8] = '{0, 1, 1023, 1022, 512, 513, 0, 1023};
   localparam int unsigned HOT_Y [8] = '{0, 0, 511, 511, 256, 256, 511, 0};

   typedef struct packed {
      logic                cmd;
      logic [LX_W-1:0]     x;
      logic [LY_W-1:0]     y;
      logic                pix_valid;
      logic [COL_W-1:0]    red;
      logic [COL_W-1:0]    green;
      logic [COL_W-1:0]    blue;
      logic [IN_WGT_W-1:0] weight;
   } pixel_req_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_cmd = CMD_BLEND;
   logic [LX_W-1:0]       req_local_x = '0;
   logic [LY_W-1:0]       req_local_y = '0;
   logic                  req_pixel_valid = 1'b0;
   logic [COL_W-1:0]      req_in_red = '0;
   logic [COL_W-1:0]      req_in_green = '0;
   logic [COL_W-1:0]      req_in_blue = '0;
   logic [IN_WGT_W-1:0]   req_in_weight = '0;

   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [COL_W-1:0]      rsp_out_red;
   logic [COL_W-1:0]      rsp_out_green;
   logic [COL_W-1:0]      rsp_out_blue;
   logic [WGT_W-1:0]      rsp_out_weight;
   logic                  rsp_covered;
   logic                  rsp_was_written;

   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [PADDR_W-1:0]    paddr = '0;
   logic [PDATA_W-1:0]    pwdata = '0;
   logic [PDATA_W-1:0]    prdata;
   logic                  pready;

   logic                  run_done = 1'b0;
   int                    rsp_seen;
   int                    failures;

   int unsigned           sent_count = 0;
   int unsigned           idle_pct = 0;
   int unsigned           stall_pct = 0;
   logic                  long_hold = 1'b0;

   weighted_panorama_blend DUT (.*);

   wpb_checker pano_check (.*);

   initial forever #5 clock = ~clock;

   // receiver: random stalls, plus one long hold-off so the block backs up
   initial begin : rsp_drain
      int unsigned hold_left;
      bit          hold_taken;
      hold_left = 0;
      hold_taken = 1'b0;
      forever begin
         @(posedge clock);
         // start the hold once the sender is offering again
         if (long_hold && req_valid && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   function automatic pixel_req_t make_req(input logic cmd, input int unsigned x, y,
                                           input logic v, input int unsigned r, g, b, w);
      return '{cmd: cmd, x: LX_W'(x), y: LY_W'(y), pix_valid: v, red: COL_W'(r),
               green: COL_W'(g), blue: COL_W'(b), weight: IN_WGT_W'(w)};
   endfunction

   function automatic logic [COL_W-1:0] pick_color();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         default: return COL_W'($urandom);
      endcase
   endfunction

   task automatic offer_pixel(input pixel_req_t p);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= p.cmd;
      req_local_x     <= p.x;
      req_local_y     <= p.y;
      req_pixel_valid <= p.pix_valid;
      req_in_red      <= p.red;
      req_in_green    <= p.green;
      req_in_blue     <= p.blue;
      req_in_weight   <= p.weight;
      do @(posedge clock); while (!req_ready);
      sent_count++;
   endtask

   task automatic csr_access(input logic wr, input logic [1:0] idx,
                             input logic [PDATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= PADDR_W'({idx, 2'b00});
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // registers change only once every word has come back
   task automatic set_config(input logic [MODE_W-1:0] mode, input int unsigned ox, oy);
      req_valid <= 1'b0;
      while (rsp_seen != sent_count) @(posedge clock);
      csr_access(1'b1, REG_BLEND_MODE, PDATA_W'(mode));
      csr_access(1'b1, REG_OFFSET_X, PDATA_W'(ox));
      csr_access(1'b1, REG_OFFSET_Y, PDATA_W'(oy));
      csr_access(1'b0, REG_BLEND_MODE, '0);
      csr_access(1'b0, REG_OFFSET_X, '0);
      csr_access(1'b0, REG_OFFSET_Y, '0);
   endtask

   task automatic run_phase(input logic [MODE_W-1:0] mode, input int unsigned ox, oy,
                            input int unsigned idle, stall, count);
      pixel_req_t  p;
      int unsigned tx, ty, h, pick;
      set_config(mode, ox, oy);
      idle_pct = idle;
      stall_pct <= stall;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            h = $urandom_range(7);
            tx = HOT_X[h];
            ty = HOT_Y[h];
         end else begin
            tx = $urandom_range(1023);
            ty = $urandom_range(511);
         end
         p.cmd = ($urandom_range(4) == 0) ? CMD_READ : CMD_BLEND;
         if (p.cmd == CMD_READ) begin
            p.x = LX_W'(tx);
            p.y = LY_W'(ty);
         end else if (pick >= 90 || tx < ox || ty < oy) begin
            // raw tile coordinates, often past the panorama edge
            p.x = LX_W'($urandom);
            p.y = LY_W'($urandom);
         end else begin
            p.x = LX_W'(tx - ox);
            p.y = LY_W'(ty - oy);
         end
         p.pix_valid = ($urandom_range(9) != 0);
         p.red   = pick_color();
         p.green = pick_color();
         p.blue  = pick_color();
         case ($urandom_range(9))
            0:       p.weight = '0;
            1:       p.weight = '1;
            2, 3:    p.weight = IN_WGT_W'($urandom_range(255));
            default: p.weight = IN_WGT_W'($urandom_range(65535, 32768));
         endcase
         offer_pixel(p);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset setup: weighted blend, no offset
      offer_pixel(make_req(CMD_READ, 0, 0, 1'b0, 0, 0, 0, 0));
      offer_pixel(make_req(CMD_READ, 1023, 511, 1'b1, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF));
      offer_pixel(make_req(CMD_BLEND, 0, 0, 1'b1, 'hFFFF, 'hFFFF, 'hFFFF, 0));
      // covered with zero weight on both sides
      offer_pixel(make_req(CMD_BLEND, 0, 0, 1'b1, 'h1234, 'h5678, 'h9ABC, 0));
      offer_pixel(make_req(CMD_BLEND, 0, 0, 1'b1, 0, 0, 0, 'hFFFF));
      offer_pixel(make_req(CMD_BLEND, 1023, 511, 1'b1, 'h8001, 'h7FFE, 'h0FFF, 'hFFFF));
      offer_pixel(make_req(CMD_BLEND, 1023, 511, 1'b1, 'hFFFF, 0, 'hAAAA, 1));
      offer_pixel(make_req(CMD_BLEND, 1023, 511, 1'b0, 0, 'hFFFF, 0, 'hFFFF));
      offer_pixel(make_req(CMD_BLEND, 700, 300, 1'b0, 'h5555, 'h5555, 'h5555, 'h5555));

      set_config(MODE_OVERWRITE, 1023, 511);
      offer_pixel(make_req(CMD_BLEND, 0, 0, 1'b1, 'h0F0F, 'hF0F0, 'h3333, 'h1111));
      offer_pixel(make_req(CMD_BLEND, 1, 0, 1'b1, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF));
      offer_pixel(make_req(CMD_BLEND, 0, 1, 1'b1, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF));
      offer_pixel(make_req(CMD_BLEND, 1023, 511, 1'b1, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF));
      offer_pixel(make_req(CMD_READ, 1023, 511, 1'b0, 0, 0, 0, 0));

      set_config(MODE_AVERAGE, 0, 0);
      offer_pixel(make_req(CMD_BLEND, 5, 5, 1'b1, 'h2001, 'h0003, 'hFFFF, 'h4000));
      offer_pixel(make_req(CMD_BLEND, 5, 5, 1'b1, 'h1000, 'hFFFF, 'hFFFF, 'h4000));
      offer_pixel(make_req(CMD_BLEND, 0, 0, 1'b1, 'hFFFF, 'hFFFF, 'hFFFF, 0));

      set_config(MODE_SPARE, 0, 0);
      offer_pixel(make_req(CMD_BLEND, 5, 5, 1'b1, 'hFFFF, 0, 'h8000, 'hFFFF));
      offer_pixel(make_req(CMD_BLEND, 0, 0, 1'b1, 'h0001, 'hFFFE, 'h7FFF, 'h8000));
      offer_pixel(make_req(CMD_READ, 5, 5, 1'b1, 0, 0, 0, 0));

      run_phase(MODE_WEIGHTED, 0, 0, 0, 0, 260);
      run_phase(MODE_AVERAGE, 17, 3, 48, 0, 200);
      run_phase(MODE_OVERWRITE, 1023, 511, 0, 48, 140);
      long_hold <= 1'b1;
      run_phase(MODE_SPARE, 0, 0, 13, 13, 250);
      run_phase(MODE_WEIGHTED, 512, 256, 0, 48, 250);
      run_phase(MODE_WEIGHTED, 0, 0, 48, 0, 250);
      run_phase(MODE_AVERAGE, 1, 0, 13, 13, 180);

      req_valid <= 1'b0;
      while (rsp_seen != sent_count) @(posedge clock);
      repeat (40) @(posedge clock);
      run_done <= 1'b1;
      repeat (2) @(posedge clock);
      if (failures == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

   // clearing pass alone is about 5.2 ms
   initial begin
      #60_000_000;
      $display("testbench: FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/wpb_pkg.sv
hdl/weighted_panorama_blend.sv
verif/wpb_checker.sv
verif/testbench.sv
